// ===== sv/page_cache_lru_tag_manager_unit_macros.svh =====
// ============================================================================
// Assertion macros for the page cache tag manager
// Clocked property helpers with a synchronous active-low reset as disable.
// ============================================================================
`ifndef PAGE_CACHE_LRU_TAG_MANAGER_UNIT_MACROS_SVH
`define PAGE_CACHE_LRU_TAG_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication
`define PCLRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PCLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pclru_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pclru_pkg
// Types and constants shared by the page cache tag manager and its cells.
// ============================================================================
package pclru_pkg;

    // Fixed field widths of the ports
    localparam int KIND_W  = 2;
    localparam int PAGE_W  = 48;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 4;
    localparam int STAMP_W = 32;

    // Defaults for the top-level parameters
    localparam int NUM_SLOTS_DEF = 8;
    localparam int PAGE_BITS_DEF = 48;

    // Reset value of the active slot count register
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Positions in the index bundle carried by the probe
    // IX_SEL: hit slot on scans, target slot on mark and commit passes
    localparam int IX_SEL  = 0;
    localparam int IX_FREE = 1;
    localparam int IX_OLD  = 2;
    localparam int IX_BAD  = 3;
    localparam int IX_N    = 4;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_WT    = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_MARK  = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        RES_GRANT = 2'd0,
        RES_WB    = 2'd1,
        RES_DONE  = 2'd2,
        RES_ERROR = 2'd3
    } t_res_kind;

    // Operation carried by the probe along the cell row
    typedef enum logic [2:0] {
        OP_ALLOC_SCAN = 3'd0,
        OP_WT_SCAN    = 3'd1,
        OP_FLUSH      = 3'd2,
        OP_MARK       = 3'd3,
        OP_COMMIT     = 3'd4,
        OP_WT_APPLY   = 3'd5
    } t_probe_op;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_APPLY = 2'd2
    } t_state;

    // Probe control: op, search flags, running oldest stamp, use clock
    typedef struct packed {
        t_probe_op          op;
        logic               hit;
        logic               free;
        logic               old;
        logic               bad;
        logic [STAMP_W-1:0] old_key;
        logic [STAMP_W-1:0] clock;
    } t_probe;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PAGE_W-1:0] page_number;
        logic [IDX_W-1:0]  target_slot;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [IDX_W-1:0]  slot_index;
        logic [PAGE_W-1:0] page_out;
        logic              was_hit;
        logic              last_result;
    } t_res;

endpackage

// ===== sv/pclru_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pclru_cell
// One cache slot: holds its tag state and acts on the probe passing through,
// then registers the probe and hands it to the next cell.
// ============================================================================
module pclru_cell
    import pclru_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int SLOT_W    = 3,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_active,
    input  logic                         i_vld,
    input  t_probe                       i_ctl,
    input  logic [PAGE_BITS-1:0]         i_page,
    input  logic [IX_N-1:0][SLOT_W-1:0]  i_idx,
    output logic                         o_vld,
    output t_probe                       o_ctl,
    output logic [PAGE_BITS-1:0]         o_page,
    output logic [IX_N-1:0][SLOT_W-1:0]  o_idx,
    output logic                         o_wb,
    output logic [PAGE_BITS-1:0]         o_wb_page
);

    localparam logic [SLOT_W-1:0] ME = SLOT_W'(IDX);

    // Slot state
    logic [PAGE_BITS-1:0] r_slot_page,  n_slot_page;
    logic                 r_slot_tag,   n_slot_tag;
    logic                 r_slot_dv,    n_slot_dv;
    logic                 r_slot_dirty, n_slot_dirty;
    logic [STAMP_W-1:0]   r_slot_stamp, n_slot_stamp;

    // Probe stage
    logic                        r_probe_vld;
    t_probe                      r_probe_ctl,  n_probe_ctl;
    logic [PAGE_BITS-1:0]        r_probe_page, n_probe_page;
    logic [IX_N-1:0][SLOT_W-1:0] r_probe_idx,  n_probe_idx;

    logic match;

    // Slot action on the passing probe
    always_comb begin
        n_probe_ctl  = i_ctl;
        n_probe_page = i_page;
        n_probe_idx  = i_idx;
        n_slot_page  = r_slot_page;
        n_slot_tag   = r_slot_tag;
        n_slot_dv    = r_slot_dv;
        n_slot_dirty = r_slot_dirty;
        n_slot_stamp = r_slot_stamp;
        o_wb         = 1'b0;
        match        = r_slot_tag && (r_slot_page == i_page);
        if (i_vld && i_active) begin
            case (i_ctl.op)
                OP_ALLOC_SCAN: begin
                    if (r_slot_dv && r_slot_dirty) begin
                        o_wb         = 1'b1;
                        n_slot_dirty = 1'b0;
                    end
                    if (match && !i_ctl.hit) begin
                        n_probe_ctl.hit     = 1'b1;
                        n_probe_idx[IX_SEL] = ME;
                    end
                    if (!r_slot_tag && !i_ctl.free) begin
                        n_probe_ctl.free     = 1'b1;
                        n_probe_idx[IX_FREE] = ME;
                    end
                    // oldest stamp, signed compare, first one wins a tie
                    if (!i_ctl.old || ($signed(r_slot_stamp) < $signed(i_ctl.old_key))) begin
                        n_probe_ctl.old     = 1'b1;
                        n_probe_ctl.old_key = r_slot_stamp;
                        n_probe_idx[IX_OLD] = ME;
                    end
                end
                OP_WT_SCAN: begin
                    if (match && !i_ctl.hit) begin
                        n_probe_ctl.hit     = 1'b1;
                        n_probe_idx[IX_SEL] = ME;
                    end
                    if (match && r_slot_dirty && !i_ctl.bad) begin
                        n_probe_ctl.bad     = 1'b1;
                        n_probe_idx[IX_BAD] = ME;
                    end
                end
                OP_FLUSH: begin
                    if (r_slot_dv && r_slot_dirty) begin
                        o_wb         = 1'b1;
                        n_slot_dirty = 1'b0;
                    end
                end
                OP_MARK: begin
                    if (i_idx[IX_SEL] == ME) begin
                        n_slot_dirty = 1'b1;
                        n_probe_page = r_slot_page;
                    end
                end
                OP_COMMIT: begin
                    if (i_idx[IX_SEL] == ME) begin
                        n_slot_stamp = i_ctl.clock;
                        if (!i_ctl.hit) begin
                            n_slot_page  = i_page;
                            n_slot_tag   = 1'b1;
                            n_slot_dv    = 1'b0;
                            n_slot_dirty = 1'b0;
                        end
                    end
                end
                OP_WT_APPLY: begin
                    if (match) begin
                        n_slot_dv         = 1'b1;
                        n_slot_dirty      = 1'b0;
                        n_slot_stamp      = i_ctl.clock;
                        n_probe_ctl.clock = i_ctl.clock + STAMP_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Slot state and probe valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_page  <= '0;
            r_slot_tag   <= 1'b0;
            r_slot_dv    <= 1'b0;
            r_slot_dirty <= 1'b0;
            r_slot_stamp <= '0;
            r_probe_vld  <= 1'b0;
        end else begin
            r_slot_page  <= n_slot_page;
            r_slot_tag   <= n_slot_tag;
            r_slot_dv    <= n_slot_dv;
            r_slot_dirty <= n_slot_dirty;
            r_slot_stamp <= n_slot_stamp;
            r_probe_vld  <= i_vld;
        end
    end

    // Probe payload
    always_ff @(posedge i_clk) begin
        r_probe_ctl  <= n_probe_ctl;
        r_probe_page <= n_probe_page;
        r_probe_idx  <= n_probe_idx;
    end

    assign o_vld     = r_probe_vld;
    assign o_ctl     = r_probe_ctl;
    assign o_page    = r_probe_page;
    assign o_idx     = r_probe_idx;
    assign o_wb_page = r_slot_page;

endmodule

// ===== sv/page_cache_lru_tag_manager_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// page_cache_lru_tag_manager_unit
// Fully associative page cache tag manager with LRU replacement, built as a
// row of slot cells through which a probe travels one cell per cycle.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  request   in         start high, busy low      i_req    (t_req)
//  result    out        o_res_strobe, one cycle   o_res    (t_res)
//  config    in         i_cfg_we                  i_cfg_data (active slot count)
//
//  Every request but a mark dirty of an inactive slot sends a probe along the
//  NUM_SLOTS cells (one cell per cycle). Flush and mark dirty take one pass;
//  allocate and writethrough hit take a second pass. Mark dirty of an inactive
//  slot returns an error without a probe. Write-back results appear as the
//  probe passes the dirty slots. Synchronous reset clears all slot state.
//  Results cannot be held off by the receiver.
//
module page_cache_lru_tag_manager_unit
    import pclru_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_res_strobe,
    output t_res              o_res
);

`include "page_cache_lru_tag_manager_unit_macros.svh"

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ACT_W  = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = ACT_W + CFG_W;

    // Configuration and control registers
    logic [CFG_W-1:0]   r_slots_in_use;
    t_state             r_state, n_state;
    logic [STAMP_W-1:0] r_use_clock, n_use_clock;
    logic               r_res_strobe, n_res_strobe;
    t_res               r_res, n_res;

    // Active slot count
    logic [CFG_W-1:0]     cfg_nz;
    logic [CMP_W-1:0]     cfg_ext;
    logic [ACT_W-1:0]     act;
    logic [NUM_SLOTS-1:0] slot_active;

    // Cell chain taps: index 0 is the launch, index NUM_SLOTS the return
    logic                        c_vld  [NUM_SLOTS+1];
    t_probe                      c_ctl  [NUM_SLOTS+1];
    logic [PAGE_BITS-1:0]        c_page [NUM_SLOTS+1];
    logic [IX_N-1:0][SLOT_W-1:0] c_idx  [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0]        cell_wb;
    logic [PAGE_BITS-1:0]        cell_wb_page [NUM_SLOTS];
    logic [NUM_SLOTS:0]          vld_vec;

    // Probe launch into the first cell
    logic                        l_vld;
    t_probe                      l_ctl;
    logic [PAGE_BITS-1:0]        l_page;
    logic [IX_N-1:0][SLOT_W-1:0] l_idx;

    // Write-back merge
    logic                 wb_any;
    logic [PAGE_BITS-1:0] wb_page;
    logic [SLOT_W-1:0]    wb_idx;

    // Width adaption between port fields and internal widths
    logic [PAGE_BITS+PAGE_W-1:0] page_in_wide;
    logic [PAGE_BITS-1:0]        req_page;
    logic [PAGE_W+PAGE_BITS-1:0] ret_page_wide, wb_page_wide;
    logic [SLOT_W+IDX_W-1:0]     tgt_wide, sel_wide, bad_wide, wb_idx_wide;
    logic [ACT_W+IDX_W-1:0]      tgt_cmp, act_cmp;

    logic                 ret_vld;
    t_probe               ret_ctl;
    logic [SLOT_W-1:0]    pick;
    logic                 fin_vld;
    t_res                 fin;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_slots_in_use <= i_cfg_data;
        end
    end

    // Clip the slot count to 1 .. NUM_SLOTS
    always_comb begin
        cfg_nz  = (r_slots_in_use == '0) ? CFG_W'(1) : r_slots_in_use;
        cfg_ext = {{ACT_W{1'b0}}, cfg_nz};
        if (cfg_ext > CMP_W'(NUM_SLOTS)) begin
            act = ACT_W'(NUM_SLOTS);
        end else begin
            act = cfg_ext[ACT_W-1:0];
        end
    end

    // Launch tap
    assign c_vld[0]  = l_vld;
    assign c_ctl[0]  = l_ctl;
    assign c_page[0] = l_page;
    assign c_idx[0]  = l_idx;

    // Row of slot cells
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        assign slot_active[g] = (ACT_W'(g) < act);
        pclru_cell #(
            .IDX       (g),
            .SLOT_W    (SLOT_W),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_active  (slot_active[g]),
            .i_vld     (c_vld[g]),
            .i_ctl     (c_ctl[g]),
            .i_page    (c_page[g]),
            .i_idx     (c_idx[g]),
            .o_vld     (c_vld[g+1]),
            .o_ctl     (c_ctl[g+1]),
            .o_page    (c_page[g+1]),
            .o_idx     (c_idx[g+1]),
            .o_wb      (cell_wb[g]),
            .o_wb_page (cell_wb_page[g])
        );
    end

    for (genvar g = 0; g <= NUM_SLOTS; g++) begin : g_vld
        assign vld_vec[g] = c_vld[g];
    end

    // Merge write-backs: at most one cell holds the probe
    always_comb begin
        wb_any  = |cell_wb;
        wb_page = '0;
        wb_idx  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (cell_wb[i]) begin
                wb_page = wb_page | cell_wb_page[i];
                wb_idx  = wb_idx | SLOT_W'(i);
            end
        end
    end

    // Field width adaption
    assign page_in_wide  = {{PAGE_BITS{1'b0}}, i_req.page_number};
    assign req_page      = page_in_wide[PAGE_BITS-1:0];
    assign ret_page_wide = {{PAGE_W{1'b0}}, c_page[NUM_SLOTS]};
    assign wb_page_wide  = {{PAGE_W{1'b0}}, wb_page};
    assign tgt_wide      = {{SLOT_W{1'b0}}, i_req.target_slot};
    assign sel_wide      = {{IDX_W{1'b0}}, c_idx[NUM_SLOTS][IX_SEL]};
    assign bad_wide      = {{IDX_W{1'b0}}, c_idx[NUM_SLOTS][IX_BAD]};
    assign wb_idx_wide   = {{IDX_W{1'b0}}, wb_idx};
    assign tgt_cmp       = {{ACT_W{1'b0}}, i_req.target_slot};
    assign act_cmp       = {{IDX_W{1'b0}}, act};

    assign ret_vld = c_vld[NUM_SLOTS];
    assign ret_ctl = c_ctl[NUM_SLOTS];

    // Allocation choice: hit, else first empty, else oldest
    always_comb begin
        if (ret_ctl.hit) begin
            pick = c_idx[NUM_SLOTS][IX_SEL];
        end else if (ret_ctl.free) begin
            pick = c_idx[NUM_SLOTS][IX_FREE];
        end else begin
            pick = c_idx[NUM_SLOTS][IX_OLD];
        end
    end

    // Sequencer: launches probes and forms the final result
    always_comb begin
        n_state     = r_state;
        n_use_clock = r_use_clock;
        l_vld       = 1'b0;
        l_ctl       = '0;
        l_page      = req_page;
        l_idx       = '0;
        fin_vld     = 1'b0;
        fin         = '0;
        fin.last_result = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (t_req_kind'(i_req.kind))
                        REQ_ALLOC: begin
                            l_vld    = 1'b1;
                            l_ctl.op = OP_ALLOC_SCAN;
                            n_state  = ST_SCAN;
                        end
                        REQ_WT: begin
                            l_vld    = 1'b1;
                            l_ctl.op = OP_WT_SCAN;
                            n_state  = ST_SCAN;
                        end
                        REQ_FLUSH: begin
                            l_vld    = 1'b1;
                            l_ctl.op = OP_FLUSH;
                            n_state  = ST_SCAN;
                        end
                        REQ_MARK: begin
                            if (tgt_cmp < act_cmp) begin
                                l_vld         = 1'b1;
                                l_ctl.op      = OP_MARK;
                                l_idx[IX_SEL] = tgt_wide[SLOT_W-1:0];
                                n_state       = ST_SCAN;
                            end else begin
                                // inactive target: error straight away
                                fin_vld         = 1'b1;
                                fin.result_kind = RES_ERROR;
                                fin.slot_index  = i_req.target_slot;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (ret_vld) begin
                    n_state = ST_IDLE;
                    case (ret_ctl.op)
                        OP_ALLOC_SCAN: begin
                            l_vld         = 1'b1;
                            l_ctl.op      = OP_COMMIT;
                            l_ctl.hit     = ret_ctl.hit;
                            l_ctl.clock   = r_use_clock;
                            l_page        = c_page[NUM_SLOTS];
                            l_idx[IX_SEL] = pick;
                            n_use_clock   = r_use_clock + STAMP_W'(1);
                            n_state       = ST_APPLY;
                        end
                        OP_WT_SCAN: begin
                            if (ret_ctl.bad) begin
                                fin_vld         = 1'b1;
                                fin.result_kind = RES_ERROR;
                                fin.slot_index  = bad_wide[IDX_W-1:0];
                                fin.page_out    = ret_page_wide[PAGE_W-1:0];
                                fin.was_hit     = 1'b1;
                            end else if (!ret_ctl.hit) begin
                                fin_vld         = 1'b1;
                                fin.result_kind = RES_DONE;
                                fin.page_out    = ret_page_wide[PAGE_W-1:0];
                            end else begin
                                l_vld         = 1'b1;
                                l_ctl.op      = OP_WT_APPLY;
                                l_ctl.clock   = r_use_clock;
                                l_page        = c_page[NUM_SLOTS];
                                l_idx[IX_SEL] = c_idx[NUM_SLOTS][IX_SEL];
                                n_state       = ST_APPLY;
                            end
                        end
                        OP_FLUSH: begin
                            fin_vld         = 1'b1;
                            fin.result_kind = RES_DONE;
                        end
                        OP_MARK: begin
                            fin_vld         = 1'b1;
                            fin.result_kind = RES_DONE;
                            fin.slot_index  = sel_wide[IDX_W-1:0];
                            fin.page_out    = ret_page_wide[PAGE_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_APPLY: begin
                if (ret_vld) begin
                    n_state        = ST_IDLE;
                    fin_vld        = 1'b1;
                    fin.slot_index = sel_wide[IDX_W-1:0];
                    fin.page_out   = ret_page_wide[PAGE_W-1:0];
                    if (ret_ctl.op == OP_WT_APPLY) begin
                        fin.result_kind = RES_DONE;
                        fin.was_hit     = 1'b1;
                        n_use_clock     = ret_ctl.clock;
                    end else begin
                        fin.result_kind = RES_GRANT;
                        fin.was_hit     = ret_ctl.hit;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: write-back transfer or final result
    always_comb begin
        n_res_strobe = fin_vld || wb_any;
        if (fin_vld) begin
            n_res = fin;
        end else begin
            n_res             = '0;
            n_res.result_kind = RES_WB;
            n_res.slot_index  = wb_idx_wide[IDX_W-1:0];
            n_res.page_out    = wb_page_wide[PAGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_use_clock  <= '0;
            r_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_use_clock  <= n_use_clock;
            r_res_strobe <= n_res_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

    // Checks; the launch tap may overlap the returning probe, so cell outputs only
    `PCLRU_ASSERT_NOW(a_one_probe, i_clk, i_rst_n, 1'b1, $onehot0(vld_vec[NUM_SLOTS:1]), "more than one probe in the cell row")
    `PCLRU_ASSERT_NOW(a_one_wb, i_clk, i_rst_n, 1'b1, $onehot0(cell_wb), "more than one write-back in a cycle")
    `PCLRU_ASSERT_NOW(a_no_clash, i_clk, i_rst_n, fin_vld, !wb_any, "final result clashes with a write-back")
    `PCLRU_ASSERT_NOW(a_ret_busy, i_clk, i_rst_n, ret_vld, r_state != ST_IDLE, "probe returned while idle")

endmodule
